// File: rtl/rta_pkg.sv
// Shared types and constants of the region table allocator.
package rta_pkg;

  localparam int unsigned MaxRegions = 512;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CHECK   = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_BEYOND   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic CFG_POOL_BASE = 1'b0;
  localparam logic CFG_POOL_SIZE = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] req_size;
    logic [31:0] req_addr;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] alloc_addr;
    logic        is_inside;
  } rsp_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] len;
  } entry_t;

  // Per-cycle command to every cell.
  typedef struct packed {
    logic        shift_down;
    logic        load;
    logic [31:0] base;
    logic [31:0] len;
  } cell_ctl_t;

endpackage

// File: rtl/region_table_allocator_unit.sv
// Region table allocator top level: control sequencer over a row of cells.
// One request raises done after a walk of the table (skipped when it is empty), one
// entry a cycle through a registered read port, followed by the decide, last and
// apply states; an insert or removal shifts all affected cells together. Exactly
// one result beat per request, shown for one cycle on done; the receiver cannot
// stall it.
module region_table_allocator_unit #(
  parameter int unsigned MAX_REGIONS = rta_pkg::MaxRegions,
  localparam int unsigned IdxW = $clog2(MAX_REGIONS),
  localparam int unsigned CntW = $clog2(MAX_REGIONS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rta_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output rta_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_DECIDE, S_APPLY} state_t;

  state_t             state;
  rta_pkg::req_t      cur;
  logic [31:0]        pool_base, pool_size;
  logic [CntW-1:0]    count;
  logic [CntW-1:0]    idx;
  logic [CntW-1:0]    hit_idx;
  logic               hit;
  logic               gap_found;
  logic [32:0]        gap_start;
  logic [32:0]        prev_end;
  logic [32:0]        first_hole;
  logic [32:0]        cand;
  logic [32:0]        pool_end;
  logic [32:0]        pool_lim;
  logic [33:0]        need;
  logic               alloc_ok;
  rta_pkg::cell_ctl_t ctl;
  rta_pkg::entry_t    rd_entry;
  logic [32:0]        rd_end;
  logic [32:0]        gap;
  logic               rd_valid;

  assign cfg_ready = 1'b1;
  assign rd_end = {1'b0, rd_entry.base} + {1'b0, rd_entry.len};
  assign gap = ({1'b0, rd_entry.base} >= prev_end) ?
               ({1'b0, rd_entry.base} - prev_end) : '0;
  assign pool_end = {1'b0, pool_base} + {1'b0, pool_size};
  // pool end clipped at the top of the address space
  assign pool_lim = pool_end[32] ? 33'h1_0000_0000 : pool_end;
  assign need = {1'b0, cand} + {2'b0, cur.req_size};
  assign alloc_ok = (cur.req_size != '0) && (count < CntW'(MAX_REGIONS)) &&
                    (need <= {1'b0, pool_lim});

  rta_chain #(.MAX_REGIONS(MAX_REGIONS)) u_chain (
    .clk(clk), .count(count), .ctl(ctl), .del_idx(hit_idx[IdxW-1:0]),
    .rd_idx(idx[IdxW-1:0]), .rd_entry(rd_entry)
  );

  always_comb begin
    ctl = '0;
    ctl.base = cand[31:0];
    ctl.len  = cur.req_size;
    if (state == S_APPLY) begin
      ctl.load = (cur.op == rta_pkg::OP_ALLOC) && alloc_ok;
      ctl.shift_down = (cur.op == rta_pkg::OP_RELEASE) && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; busy <= 1'b0; done <= 1'b0; count <= '0;
      pool_base <= '0; pool_size <= '0; rd_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rta_pkg::CFG_POOL_BASE) pool_base <= cfg_data;
        else pool_size <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start && !busy) begin
            cur <= req; busy <= 1'b1; idx <= '0; hit <= 1'b0; hit_idx <= '0;
            gap_found <= 1'b0; rd_valid <= 1'b0; rsp <= '0;
            state <= (count == '0) ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          rd_valid <= 1'b1;
          if (rd_valid) begin
            // rd_entry is entry idx-1
            if (idx == CntW'(1)) first_hole <= ({1'b0, rd_entry.base} >=
                {1'b0, pool_base}) ? {1'b0, rd_entry.base} - {1'b0, pool_base} : '0;
            else if ({1'b0, cur.req_size} <= gap) begin
              gap_found <= 1'b1; gap_start <= prev_end;
            end
            prev_end <= rd_end;
            if (!hit && rd_entry.base == cur.req_addr &&
                cur.op == rta_pkg::OP_RELEASE) begin
              hit <= 1'b1; hit_idx <= idx - CntW'(1);
            end
            if (cur.op == rta_pkg::OP_CHECK && rd_entry.base <= cur.req_addr &&
                {1'b0, cur.req_addr} < rd_end) hit <= 1'b1;
          end
          if (idx == count) state <= S_DECIDE;
          else idx <= idx + CntW'(1);
        end
        S_DECIDE: begin
          if (count == '0) cand <= {1'b0, pool_base};
          else if ({1'b0, cur.req_size} <= first_hole) cand <= {1'b0, pool_base};
          else if (gap_found) cand <= gap_start;
          else cand <= prev_end;
          state <= S_LAST;
        end
        S_LAST: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          case (cur.op)
            rta_pkg::OP_ALLOC: begin
              if (cur.req_size == '0) begin
                rsp.status <= rta_pkg::ST_ZERO;
              end else if (count >= CntW'(MAX_REGIONS)) begin
                rsp.status <= rta_pkg::ST_FULL;
              end else if (need > {1'b0, pool_lim}) begin
                rsp.status <= rta_pkg::ST_BEYOND;
              end else begin
                rsp.status <= rta_pkg::ST_OK; rsp.alloc_addr <= cand[31:0];
                count <= count + CntW'(1);
              end
            end
            rta_pkg::OP_RELEASE: begin
              if (hit) count <= count - CntW'(1);
              else rsp.status <= rta_pkg::ST_NOTFOUND;
            end
            rta_pkg::OP_CHECK: rsp.is_inside <= hit;
            default: ;
          endcase
          done <= 1'b1; busy <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MAX_REGIONS)) else $error("count overflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(done) |-> $stable(count) || $past(state == S_APPLY))
    else $error("count moved outside apply");

endmodule

// File: rtl/rta_cell.sv
// One table slot: holds an entry, can insert, shift and report local matches.
module rta_cell (
  input  logic               clk,
  input  logic               valid,
  input  logic               valid_up,
  input  rta_pkg::entry_t    prev_entry,
  input  rta_pkg::entry_t    next_entry,
  input  logic               prev_lower,
  input  rta_pkg::cell_ctl_t ctl,
  output rta_pkg::entry_t    entry,
  output logic               lower_eq
);

  rta_pkg::entry_t entry_next;

  // lower_eq: this entry starts at or below the insert base.
  assign lower_eq = valid && (entry.base <= ctl.base);

  always_comb begin
    entry_next = entry;
    if (ctl.load) begin
      if (valid && !lower_eq) begin
        entry_next = prev_lower ? '{base: ctl.base, len: ctl.len} : prev_entry;
      end else if (!valid && valid_up) begin
        entry_next = prev_lower ? '{base: ctl.base, len: ctl.len} : prev_entry;
      end
    end else if (ctl.shift_down) begin
      if (valid) entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: rtl/rta_chain.sv
// Row of table cells with a scan port read at a stepping index.
module rta_chain #(
  parameter int unsigned MAX_REGIONS = rta_pkg::MaxRegions,
  localparam int unsigned IdxW = $clog2(MAX_REGIONS),
  localparam int unsigned CntW = $clog2(MAX_REGIONS + 1)
) (
  input  logic               clk,
  input  logic [CntW-1:0]    count,
  input  rta_pkg::cell_ctl_t ctl,
  input  logic [IdxW-1:0]    del_idx,
  input  logic [IdxW-1:0]    rd_idx,
  output rta_pkg::entry_t    rd_entry
);

  rta_pkg::entry_t entries [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] lower;
  logic [MAX_REGIONS-1:0] valid;
  logic [MAX_REGIONS-1:0] valid_up;

  for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
    rta_pkg::entry_t   pe;
    rta_pkg::entry_t   ne;
    logic              pl;
    rta_pkg::cell_ctl_t c;
    assign valid[g] = (CntW'(g) < count);
    assign valid_up[g] = (CntW'(g) == count);
    if (g == 0) begin : g_first
      assign pe = '0;
      assign pl = 1'b1;
    end else begin : g_mid
      assign pe = entries[g-1];
      assign pl = lower[g-1] || !valid[g-1];
    end
    if (g == MAX_REGIONS - 1) begin : g_last
      assign ne = '0;
    end else begin : g_nl
      assign ne = entries[g+1];
    end
    always_comb begin
      c = ctl;
      c.shift_down = ctl.shift_down && (IdxW'(g) >= del_idx);
    end
    rta_cell u_cell (
      .clk(clk), .valid(valid[g]),
      .valid_up(valid_up[g]),
      .prev_entry(pe), .next_entry(ne), .prev_lower(pl), .ctl(c),
      .entry(entries[g]), .lower_eq(lower[g])
    );
  end

  always_ff @(posedge clk) begin
    rd_entry <= entries[rd_idx];
  end

endmodule

// File: tb/region_table_allocator_unit_checker.sv
// Checker for the region table allocator: predicts each result and compares it.
module region_table_allocator_unit_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  rta_pkg::req_t req,
  input  logic          done,
  input  rta_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] pool_base_q;
  logic [31:0] pool_size_q;
  logic [31:0] tbl_base [rta_pkg::MaxRegions];
  logic [31:0] tbl_len [rta_pkg::MaxRegions];
  int unsigned tbl_n;
  rta_pkg::rsp_t expected_q[$];

  assign pending = expected_q.size();

  function automatic logic [32:0] tbl_end(int unsigned i);
    return {1'b0, tbl_base[i]} + {1'b0, tbl_len[i]};
  endfunction

  function automatic rta_pkg::rsp_t predict_allocate(logic [31:0] sz);
    rta_pkg::rsp_t r;
    logic [32:0] at;
    logic [32:0] lim;
    logic [32:0] hole;
    logic [32:0] gap;
    int unsigned pos;
    r = '0;
    if (sz == 0) begin
      r.status = rta_pkg::ST_ZERO;
      return r;
    end
    if (tbl_n >= rta_pkg::MaxRegions) begin
      r.status = rta_pkg::ST_FULL;
      return r;
    end
    if (tbl_n == 0) begin
      at = {1'b0, pool_base_q};
    end else begin
      hole = (tbl_base[0] >= pool_base_q) ? {1'b0, tbl_base[0] - pool_base_q} : '0;
      if ({1'b0, sz} <= hole) begin
        at = {1'b0, pool_base_q};
      end else begin
        at = tbl_end(tbl_n - 1);
        for (int unsigned i = 0; i + 1 < tbl_n; i++) begin
          gap = ({1'b0, tbl_base[i+1]} >= tbl_end(i)) ?
                {1'b0, tbl_base[i+1]} - tbl_end(i) : '0;
          if ({1'b0, sz} <= gap) at = tbl_end(i);
        end
      end
    end
    lim = {1'b0, pool_base_q} + {1'b0, pool_size_q};
    if (lim > 33'h1_0000_0000) lim = 33'h1_0000_0000;
    if ({1'b0, at} + {2'b0, sz} > {1'b0, lim}) begin
      r.status = rta_pkg::ST_BEYOND;
      return r;
    end
    pos = tbl_n;
    while (pos > 0 && {1'b0, tbl_base[pos-1]} > at) begin
      tbl_base[pos] = tbl_base[pos-1];
      tbl_len[pos] = tbl_len[pos-1];
      pos--;
    end
    tbl_base[pos] = at[31:0];
    tbl_len[pos] = sz;
    tbl_n++;
    r.status = rta_pkg::ST_OK;
    r.alloc_addr = at[31:0];
    return r;
  endfunction

  function automatic rta_pkg::rsp_t predict_response(rta_pkg::req_t q);
    rta_pkg::rsp_t r;
    r = '0;
    case (q.op)
      rta_pkg::OP_ALLOC: r = predict_allocate(q.req_size);
      rta_pkg::OP_RELEASE: begin
        r.status = rta_pkg::ST_NOTFOUND;
        for (int unsigned i = 0; i < tbl_n; i++) begin
          if (tbl_base[i] == q.req_addr) begin
            for (int unsigned j = i; j + 1 < tbl_n; j++) begin
              tbl_base[j] = tbl_base[j+1];
              tbl_len[j] = tbl_len[j+1];
            end
            tbl_n--;
            r.status = rta_pkg::ST_OK;
            break;
          end
        end
      end
      rta_pkg::OP_CHECK: begin
        for (int unsigned i = 0; i < tbl_n; i++)
          if (tbl_base[i] <= q.req_addr && {1'b0, q.req_addr} < tbl_end(i))
            r.is_inside = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    rta_pkg::rsp_t want;
    if (rst) begin
      pool_base_q <= '0;
      pool_size_q <= '0;
      tbl_n = 0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rta_pkg::CFG_POOL_BASE) pool_base_q <= cfg_data;
        else pool_size_q <= cfg_data;
      end
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, rsp);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.status !== rsp.status || want.alloc_addr !== rsp.alloc_addr ||
              want.is_inside !== rsp.is_inside) begin
            $display("%0t: mismatch, expected %0d/%h/%b, actual %0d/%h/%b", $time,
                     want.status, want.alloc_addr, want.is_inside,
                     rsp.status, rsp.alloc_addr, rsp.is_inside);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_q.push_back(predict_response(req));
    end
  end
endmodule

// File: tb/region_table_allocator_unit_tb.sv
// Testbench top for the region table allocator: stimulus and verdict.
module region_table_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic          clk;
  logic          rst;
  logic          start;
  rta_pkg::req_t req;
  logic          busy;
  logic          done;
  rta_pkg::rsp_t rsp;
  logic          cfg_valid;
  logic          cfg_ready;
  logic          cfg_index;
  logic [31:0]   cfg_data;
  int            fail_count;
  int            pending;
  int            cycles;
  bit            full_seen;
  logic [31:0]   live_bases[$];

  localparam int CycleLimit = 3_000_000;

  region_table_allocator_unit dut (.*);

  region_table_allocator_unit_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_pool(logic [31:0] base, logic [31:0] len);
    cfg_valid <= 1'b1;
    for (int k = 0; k < 2; k++) begin
      cfg_index <= (k == 0) ? rta_pkg::CFG_POOL_BASE : rta_pkg::CFG_POOL_SIZE;
      cfg_data <= (k == 0) ? base : len;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (rta_pkg::MaxRegions + 20) @(posedge clk);
  endtask

  // start stays high after the beat so the next one can follow at once
  task automatic send(logic [1:0] op, logic [31:0] sz, logic [31:0] addr, bit gaps);
    int idle;
    idle = gaps ? $urandom_range(0, 19) : 0;
    if (idle != 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    start <= 1'b1;
    req <= '{op: op, req_size: sz, req_addr: addr};
    do @(posedge clk); while (busy);
  endtask

  task automatic random_phase(int count, logic [31:0] unit, bit gaps);
    logic [1:0] op;
    logic [31:0] a;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: op = rta_pkg::OP_ALLOC;
        4, 5, 6: op = rta_pkg::OP_RELEASE;
        7, 8: op = rta_pkg::OP_CHECK;
        default: op = 2'd3;
      endcase
      a = $urandom;
      if (live_bases.size() != 0 && $urandom_range(0, 3) != 0)
        a = live_bases[$urandom_range(0, live_bases.size() - 1)] + $urandom_range(0, 1) *
            $urandom_range(0, unit);
      send(op, ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, unit * 3),
           a, gaps && ($urandom_range(0, 3) != 0));
      if (op == rta_pkg::OP_ALLOC) begin
        start <= 1'b0;
        do @(posedge clk); while (!done);
        if (rsp.status == rta_pkg::ST_OK) live_bases.push_back(rsp.alloc_addr);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = rta_pkg::CFG_POOL_BASE;
    cfg_data = '0;
    full_seen = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pool, then a small pool
    send(rta_pkg::OP_ALLOC, 32'd1, '0, 0);
    send(rta_pkg::OP_ALLOC, '0, '0, 0);
    send(2'd3, '1, '1, 0);
    send(rta_pkg::OP_RELEASE, '0, '0, 0);
    drain();
    write_pool(32'h0000_1000, 32'h0000_0100);
    send(rta_pkg::OP_ALLOC, 32'h40, '0, 0);
    send(rta_pkg::OP_ALLOC, 32'h40, '0, 0);
    send(rta_pkg::OP_ALLOC, 32'h40, '0, 0);
    send(rta_pkg::OP_RELEASE, '0, 32'h1040, 0);
    send(rta_pkg::OP_ALLOC, 32'h20, '0, 0);
    send(rta_pkg::OP_CHECK, '0, 32'h1000, 0);
    send(rta_pkg::OP_CHECK, '0, 32'h103f, 0);
    send(rta_pkg::OP_CHECK, '0, 32'h1060, 0);
    send(rta_pkg::OP_ALLOC, 32'h100, '0, 0);
    send(rta_pkg::OP_ALLOC, '1, '0, 0);
    send(rta_pkg::OP_RELEASE, '0, 32'h1000, 0);
    send(rta_pkg::OP_ALLOC, 32'h40, '0, 0);
    send(rta_pkg::OP_RELEASE, '0, 32'h1234, 0);
    drain();
    // pool ending at 2^32 and beyond: clipped; base moved above existing regions
    write_pool(32'hFFFF_FF00, '1);
    send(rta_pkg::OP_ALLOC, 32'h100, '0, 0);
    send(rta_pkg::OP_ALLOC, 32'h1, '0, 0);
    send(rta_pkg::OP_CHECK, '0, '1, 0);
    drain();
    write_pool('0, '1);
    send(rta_pkg::OP_ALLOC, 32'h10, '0, 0);
    send(rta_pkg::OP_RELEASE, '0, '0, 0);
    drain();

    write_pool(32'h0001_0000, 32'h0000_0800);
    random_phase(20, 32'h40, 1);
    drain();
    write_pool($urandom, $urandom);
    random_phase(15, 32'h1000, 1);
    drain();
    write_pool('1, '1);
    random_phase(10, 32'h8, 0);
    drain();
    write_pool('0, 32'h0000_0400);
    random_phase(15, 32'h20, 1);
    drain();

    // fill the table to full with unit sizes
    write_pool('0, '1);
    for (int n = 0; n <= rta_pkg::MaxRegions && !full_seen; n++) begin
      send(rta_pkg::OP_ALLOC, 32'd1, '0, 0);
      start <= 1'b0;
      do @(posedge clk); while (!done);
      full_seen = (rsp.status == rta_pkg::ST_FULL);
    end
    send(rta_pkg::OP_ALLOC, '0, '0, 0);
    send(rta_pkg::OP_CHECK, '0, 32'd511, 0);
    drain();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
